FILE: hw/rtl/bandwidth_vote_conditioner_macros.svh
// Assertion macros shared by the bandwidth vote conditioner RTL.
`ifndef BANDWIDTH_VOTE_CONDITIONER_MACROS_SVH
`define BANDWIDTH_VOTE_CONDITIONER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define BVC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bvc: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define BVC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bvc: next-cycle check failed");

`endif

FILE: hw/rtl/bvc_pkg.sv
// Types, constants and helpers shared by the bandwidth vote conditioner.
package bvc_pkg;

  localparam int MAX_PATH_COUNT = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MBPS_W     = 16;
  localparam int AVG_MBPS_W = 17;
  localparam int PCT_W      = 9;
  localparam int KBPS_W     = 32;

  localparam logic [1:0] PATH_ONE  = 2'd1;
  localparam logic [1:0] PATH_DUAL = 2'd2;

  localparam logic MODE_REQUEST = 1'b0;
  localparam logic MODE_OUTCOME = 1'b1;
  localparam logic [1:0] OUTCOME_ACCEPTED = 2'd0;

  localparam logic [PCT_W-1:0] PCT_UNITY   = 9'd100;
  localparam logic [PCT_W-1:0] UPSCALE_MAX = 9'd300;
  localparam logic [PCT_W-1:0] BOOST_MAX   = 9'd400;

  // mbps * 2^20 / 1000 == mbps * 2^17 / 125; halving drops one more bit of shift
  localparam int KBPS_SHIFT = 17;

  // Constant divider: 16-bit digits, remainder below 128, reciprocal estimate
  // exact for every 23-bit partial dividend with divisor 125 or 100.
  localparam int DIGIT_W     = 16;
  localparam int DIV_DIGITS  = 3;
  localparam int DIVIDEND_W  = DIGIT_W * DIV_DIGITS;
  localparam int REM_W       = 7;
  localparam int PART_W      = REM_W + DIGIT_W;
  localparam int RECIP_W     = 24;
  localparam int RECIP_SHIFT = 30;
  localparam int EST_W       = PART_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_KILO = 24'd8589935;   // ceil(2^30 / 125)
  localparam logic [RECIP_W-1:0] RECIP_CENT = 24'd10737419;  // ceil(2^30 / 100)

  typedef enum logic [2:0] {
    REG_PEAK_SHARED = 3'd0,
    REG_SPLIT_AVG   = 3'd1,
    REG_PATH_COUNT  = 3'd2,
    REG_UPSCALE_PCT = 3'd3,
    REG_BOOST_PCT   = 3'd4,
    REG_MIN_AVG     = 3'd5,
    REG_MIN_PEAK    = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_SCALE_UP,
    ST_SCALE_BOOST,
    ST_DONE
  } bvc_state_t;

  typedef enum logic [1:0] {
    PH_KBPS,
    PH_UPSCALE,
    PH_BOOST
  } bvc_phase_t;

  typedef enum logic [1:0] {
    LANE_HOLD,
    LANE_LOAD_KBPS,
    LANE_LOAD_SCALE,
    LANE_DIV_STEP
  } lane_op_t;

  typedef struct packed {
    lane_op_t lane_op;
    logic     div_kilo;   // divide by 125 (rate conversion) instead of 100
    logic     use_boost;  // scale by the boost percent instead of upscale
    logic     out_load;
    logic     busy;
  } bvc_cmd_t;

  typedef struct packed {
    logic start;
    logic do_up;
    logic do_boost;
    logic out_free;
  } bvc_status_t;

  function automatic logic [PCT_W-1:0] clamp_pct(input logic [PCT_W-1:0] v,
                                                 input logic [PCT_W-1:0] maxv);
    logic [PCT_W-1:0] r;
    r = v;
    if (v != '0 && v < PCT_UNITY) begin
      r = PCT_UNITY;
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/bvc_ctrl.sv
// Sequencer for the vote conditioner: steps the lanes through convert and scale.
module bvc_ctrl import bvc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  bvc_status_t status,
  output bvc_cmd_t    cmd
);

  localparam int CNT_W = $clog2(DIV_DIGITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_DIGITS - 1);

  bvc_state_t       state, state_next;
  bvc_phase_t       phase, phase_next;
  logic [CNT_W-1:0] digit_cnt, digit_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_KBPS;
      digit_cnt <= '0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      digit_cnt <= digit_cnt_next;
    end
  end

  always_comb begin
    state_next     = state;
    phase_next     = phase;
    digit_cnt_next = digit_cnt;
    case (state)
      ST_IDLE: begin
        if (status.start) begin
          state_next = ST_LOAD;
          phase_next = PH_KBPS;
        end
      end
      ST_LOAD: begin
        state_next     = ST_DIV;
        digit_cnt_next = '0;
      end
      ST_DIV: begin
        if (digit_cnt == CNT_LAST) begin
          case (phase)
            PH_KBPS: begin
              if (status.do_up) begin
                state_next = ST_SCALE_UP;
              end else if (status.do_boost) begin
                state_next = ST_SCALE_BOOST;
              end else begin
                state_next = ST_DONE;
              end
            end
            PH_UPSCALE: begin
              state_next = status.do_boost ? ST_SCALE_BOOST : ST_DONE;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end else begin
          digit_cnt_next = digit_cnt + 1'b1;
        end
      end
      ST_SCALE_UP: begin
        state_next     = ST_DIV;
        phase_next     = PH_UPSCALE;
        digit_cnt_next = '0;
      end
      ST_SCALE_BOOST: begin
        state_next     = ST_DIV;
        phase_next     = PH_BOOST;
        digit_cnt_next = '0;
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.lane_op   = LANE_HOLD;
    cmd.div_kilo  = 1'b0;
    cmd.use_boost = 1'b0;
    cmd.out_load  = 1'b0;
    cmd.busy      = (state != ST_IDLE);
    case (state)
      ST_LOAD: begin
        cmd.lane_op = LANE_LOAD_KBPS;
      end
      ST_DIV: begin
        cmd.lane_op  = LANE_DIV_STEP;
        cmd.div_kilo = (phase == PH_KBPS);
      end
      ST_SCALE_UP: begin
        cmd.lane_op = LANE_LOAD_SCALE;
      end
      ST_SCALE_BOOST: begin
        cmd.lane_op   = LANE_LOAD_SCALE;
        cmd.use_boost = 1'b1;
      end
      ST_DONE: begin
        cmd.out_load = status.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hw/rtl/bvc_lane.sv
// One vote lane: rate conversion and percent scaling through a digit divider.
module bvc_lane import bvc_pkg::*; (
  input  logic                  clk,
  input  lane_op_t              op,
  input  logic                  div_kilo,
  input  logic [AVG_MBPS_W-1:0] mbps,
  input  logic                  halve,
  input  logic [PCT_W-1:0]      pct,
  output logic [KBPS_W-1:0]     quo
);

  localparam int SCALE_W = KBPS_W + PCT_W;

  logic [DIVIDEND_W-1:0] dividend;
  logic [REM_W-1:0]      rem;

  logic [DIVIDEND_W-1:0] kbps_load;
  logic [SCALE_W-1:0]    scale_prod;
  logic [PART_W-1:0]     part;
  logic [RECIP_W-1:0]    recip;
  logic [EST_W-1:0]      est;
  logic [DIGIT_W-1:0]    q_digit;
  logic [PART_W-1:0]     q_back;
  logic [PART_W-1:0]     part_left;

  // Split across two paths: one less bit of shift, exact since the rate is a multiple of 2^20.
  assign kbps_load = halve ? (DIVIDEND_W'(mbps) << (KBPS_SHIFT - 1))
                           : (DIVIDEND_W'(mbps) << KBPS_SHIFT);

  assign scale_prod = SCALE_W'(quo) * SCALE_W'(pct);

  // Next partial dividend: remainder above the top digit.
  assign part    = {rem, dividend[DIVIDEND_W-1 -: DIGIT_W]};
  assign recip   = div_kilo ? RECIP_KILO : RECIP_CENT;
  assign est     = EST_W'(part) * EST_W'(recip);
  assign q_digit = est[RECIP_SHIFT +: DIGIT_W];

  // q * 125 or q * 100 by shift and add
  assign q_back = div_kilo
    ? ((PART_W'(q_digit) << 7) - (PART_W'(q_digit) << 2) + PART_W'(q_digit))
    : ((PART_W'(q_digit) << 6) + (PART_W'(q_digit) << 5) + (PART_W'(q_digit) << 2));

  assign part_left = part - q_back;

  always_ff @(posedge clk) begin
    case (op)
      LANE_LOAD_KBPS: begin
        dividend <= kbps_load;
        rem      <= '0;
      end
      LANE_LOAD_SCALE: begin
        dividend <= DIVIDEND_W'(scale_prod);
        rem      <= '0;
      end
      LANE_DIV_STEP: begin
        dividend <= dividend << DIGIT_W;
        rem      <= part_left[REM_W-1:0];
        // quotient stays below 2^30, so the oldest digit drops out as zero
        quo      <= {quo[KBPS_W-DIGIT_W-1:0], q_digit};
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hw/rtl/bvc_datapath.sv
// Datapath: registers, request decode, committed state, two lanes, vote register.
module bvc_datapath import bvc_pkg::*; #(
  parameter int MAX_PATHS = MAX_PATH_COUNT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bvc_cmd_t              cmd,
  output bvc_status_t           status,
  input  logic                  item_accept,
  input  logic                  mode,
  input  logic [MBPS_W-1:0]     request_mbps,
  input  logic [MBPS_W-1:0]     governor_avg_mbps,
  input  logic                  display_on,
  input  logic                  suspend_freezing,
  input  logic [1:0]            outcome,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  vote_stall,
  output logic                  vote_valid,
  output logic [KBPS_W-1:0]     avg_kbps,
  output logic [KBPS_W-1:0]     peak_kbps
);

  localparam logic [1:0] PATH_MAX = 2'(MAX_PATHS);

  logic              peak_shared;
  logic              split_avg;
  logic [1:0]        path_count;
  logic [PCT_W-1:0]  upscale_pct;
  logic [PCT_W-1:0]  boost_pct;
  logic [KBPS_W-1:0] min_avg_kbps;
  logic [KBPS_W-1:0] min_peak_kbps;

  logic [MBPS_W-1:0]     committed_peak_mbps;
  logic [AVG_MBPS_W-1:0] committed_avg_mbps;
  logic [MBPS_W-1:0]     pending_peak_mbps;
  logic [AVG_MBPS_W-1:0] pending_avg_mbps;
  logic                  pending_valid;

  logic [AVG_MBPS_W-1:0] avg_mbps_q;
  logic [MBPS_W-1:0]     peak_mbps_q;
  logic                  disp_q;
  logic                  do_up_q;
  logic                  do_boost_q;

  logic [MBPS_W+3:0]     req_x9;
  logic [AVG_MBPS_W-1:0] avg_mbps;
  logic                  req_above;
  logic                  unchanged;
  logic                  emit;
  logic                  ramp;
  logic [1:0]            path_eff;
  logic                  paths_split;
  logic [PCT_W-1:0]      scale_pct;
  logic [KBPS_W-1:0]     avg_quo;
  logic [KBPS_W-1:0]     peak_quo;
  logic                  avg_floor_hit;
  logic                  peak_floor_hit;

  // Configuration registers, percents clamped on write
  always_ff @(posedge clk) begin
    if (rst) begin
      peak_shared   <= 1'b0;
      split_avg     <= 1'b1;
      path_count    <= PATH_ONE;
      upscale_pct   <= '0;
      boost_pct     <= '0;
      min_avg_kbps  <= '0;
      min_peak_kbps <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_PEAK_SHARED: peak_shared   <= cfg_data[0];
        REG_SPLIT_AVG:   split_avg     <= cfg_data[0];
        REG_PATH_COUNT:  path_count    <= cfg_data[1:0];
        REG_UPSCALE_PCT: upscale_pct   <= clamp_pct(cfg_data[PCT_W-1:0], UPSCALE_MAX);
        REG_BOOST_PCT:   boost_pct     <= clamp_pct(cfg_data[PCT_W-1:0], BOOST_MAX);
        REG_MIN_AVG:     min_avg_kbps  <= cfg_data[KBPS_W-1:0];
        REG_MIN_PEAK:    min_peak_kbps <= cfg_data[KBPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Request decode
  assign req_above = request_mbps > committed_peak_mbps;
  assign req_x9    = (20'(request_mbps) << 3) + 20'(request_mbps);
  assign avg_mbps  = (governor_avg_mbps != '0) ? AVG_MBPS_W'(governor_avg_mbps)
                   : (req_above ? req_x9[MBPS_W+3:3] : AVG_MBPS_W'(request_mbps));
  assign unchanged = (request_mbps == committed_peak_mbps) &&
                     (avg_mbps == committed_avg_mbps);
  assign emit      = item_accept && (mode == MODE_REQUEST) && !unchanged &&
                     !suspend_freezing;
  assign ramp      = display_on && req_above;

  // Commit on an accepted outcome, drop the pending vote on any outcome
  always_ff @(posedge clk) begin
    if (rst) begin
      committed_peak_mbps <= '0;
      committed_avg_mbps  <= '0;
      pending_peak_mbps   <= '0;
      pending_avg_mbps    <= '0;
      pending_valid       <= 1'b0;
    end else if (item_accept && mode == MODE_OUTCOME) begin
      if (pending_valid && outcome == OUTCOME_ACCEPTED) begin
        committed_peak_mbps <= pending_peak_mbps;
        committed_avg_mbps  <= pending_avg_mbps;
      end
      pending_valid <= 1'b0;
    end else if (emit) begin
      pending_peak_mbps <= request_mbps;
      pending_avg_mbps  <= avg_mbps;
      pending_valid     <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      avg_mbps_q  <= avg_mbps;
      peak_mbps_q <= request_mbps;
      disp_q      <= display_on;
      do_up_q     <= ramp && (upscale_pct > PCT_UNITY);
      do_boost_q  <= ramp && (boost_pct > PCT_UNITY);
    end
  end

  // Path count zero reads as one, above the maximum saturates
  assign path_eff    = (path_count == '0) ? PATH_ONE
                     : ((path_count > PATH_MAX) ? PATH_MAX : path_count);
  assign paths_split = (path_eff == PATH_DUAL);
  assign scale_pct   = cmd.use_boost ? boost_pct : upscale_pct;

  bvc_lane u_avg_lane (
    .clk      (clk),
    .op       (cmd.lane_op),
    .div_kilo (cmd.div_kilo),
    .mbps     (avg_mbps_q),
    .halve    (split_avg && paths_split),
    .pct      (scale_pct),
    .quo      (avg_quo)
  );

  bvc_lane u_peak_lane (
    .clk      (clk),
    .op       (cmd.lane_op),
    .div_kilo (cmd.div_kilo),
    .mbps     (AVG_MBPS_W'(peak_mbps_q)),
    .halve    (peak_shared && paths_split),
    .pct      (scale_pct),
    .quo      (peak_quo)
  );

  // Screen-on floors
  assign avg_floor_hit  = disp_q && (avg_quo != '0) && (min_avg_kbps != '0) &&
                          (avg_quo < min_avg_kbps);
  assign peak_floor_hit = disp_q && (peak_quo != '0) && (min_peak_kbps != '0) &&
                          (peak_quo < min_peak_kbps);

  always_ff @(posedge clk) begin
    if (rst) begin
      vote_valid <= 1'b0;
    end else if (cmd.out_load) begin
      vote_valid <= 1'b1;
    end else if (!vote_stall) begin
      vote_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      avg_kbps  <= avg_floor_hit ? min_avg_kbps : avg_quo;
      peak_kbps <= peak_floor_hit ? min_peak_kbps : peak_quo;
    end
  end

  assign status.start    = emit;
  assign status.do_up    = do_up_q;
  assign status.do_boost = do_boost_q;
  assign status.out_free = !vote_valid || !vote_stall;

endmodule

FILE: hw/rtl/bandwidth_vote_conditioner.sv
// Top level of the bandwidth vote conditioner: sequencer plus datapath.
//
// Item channel (item_valid / item_stall): one beat is either a governor request
// (mode 0) or an outcome report for the last issued vote (mode 1). Vote channel
// (vote_valid / vote_stall): one beat carries avg_kbps and peak_kbps.
// Outcome beats and requests that are unchanged or arrive during suspend freeze
// leave item_stall low and produce no vote. A request that produces a vote holds
// item_stall high while both lanes run: a load step, then divider digit steps
// for the MB/s to kbps conversion, a scale load and more digit steps for each
// active ramp boost, and the write of the vote register. A new item is taken
// only once the sequencer is idle again; each lane divides with 16-bit digits.
// The vote register decouples the two sides: a request can be taken while a
// previous vote still waits; the lanes then hold in the final cycle until the
// vote register is free. While vote_stall is high the vote beat holds.
// The user writes configuration via cfg_write / cfg_index / cfg_data while idle;
// the block does not enforce it. Synchronous reset returns registers to their
// defaults, clears committed and pending votes, drops any vote beat in flight.
`include "bandwidth_vote_conditioner_macros.svh"

module bandwidth_vote_conditioner import bvc_pkg::*; #(
  parameter int MAX_PATHS = MAX_PATH_COUNT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic                  mode,
  input  logic [MBPS_W-1:0]     request_mbps,
  input  logic [MBPS_W-1:0]     governor_avg_mbps,
  input  logic                  display_on,
  input  logic                  suspend_freezing,
  input  logic [1:0]            outcome,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  vote_valid,
  input  logic                  vote_stall,
  output logic [KBPS_W-1:0]     avg_kbps,
  output logic [KBPS_W-1:0]     peak_kbps
);

  bvc_cmd_t    cmd;
  bvc_status_t status;
  logic        item_accept;

  // Take items only while the sequencer is idle
  assign item_stall  = cmd.busy;
  assign item_accept = item_valid && !item_stall;

  bvc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  bvc_datapath #(
    .MAX_PATHS (MAX_PATHS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .item_accept       (item_accept),
    .mode              (mode),
    .request_mbps      (request_mbps),
    .governor_avg_mbps (governor_avg_mbps),
    .display_on        (display_on),
    .suspend_freezing  (suspend_freezing),
    .outcome           (outcome),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .vote_stall        (vote_stall),
    .vote_valid        (vote_valid),
    .avg_kbps          (avg_kbps),
    .peak_kbps         (peak_kbps)
  );

  // A request that produces a vote must close the item channel right away
  `BVC_ASSERT_NEXT(a_start_stalls_items, clk, rst, status.start, item_stall)
  // Never overwrite a vote beat that the receiver is holding off
  `BVC_ASSERT_SAME(a_no_vote_overwrite, clk, rst, cmd.out_load, !(vote_valid && vote_stall))
  // A vote beat only appears from a finished computation
  `BVC_ASSERT_SAME(a_vote_from_work, clk, rst, $rose(vote_valid), $past(cmd.out_load))
  // Lanes stay frozen whenever items can be taken
  `BVC_ASSERT_SAME(a_lanes_hold_idle, clk, rst, !item_stall, cmd.lane_op == LANE_HOLD)

endmodule

FILE: sim/bandwidth_vote_conditioner_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bandwidth vote conditioner: random and directed traffic.
module bandwidth_vote_conditioner_tb;
  import bvc_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 9;
  // Outlasts the longest request, vote register write included, with margin.
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int TARGET_BEATS  = 1950;

  localparam logic [1:0] OUTCOME_DEFERRED = 2'd1;
  localparam logic [1:0] OUTCOME_FAILED   = 2'd2;
  localparam logic [1:0] OUTCOME_RESERVED = 2'd3;
  // Index with no register behind it; the block must ignore the write.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam longint unsigned BYTES_PER_MB = 64'd1 << 20;
  localparam longint unsigned KBPS_DIVISOR = 64'd1000;
  localparam longint unsigned PERCENT      = 64'd100;
  localparam longint unsigned KBPS_CEILING = 64'hFFFF_FFFF;
  localparam int RISE_NUM = 9;
  localparam int RISE_DEN = 8;

  // Entries of the driver's work list: beats, register writes, pauses, pacing.
  typedef enum logic [1:0] {STEP_BEAT, STEP_REG_WRITE, STEP_QUIESCE, STEP_PACE} step_kind_t;

  typedef struct {
    step_kind_t           kind;
    logic                 mode;
    logic [MBPS_W-1:0]    req;
    logic [MBPS_W-1:0]    gav;
    logic                 disp;
    logic                 freeze;
    logic [1:0]           oc;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    int                   send_pct;
    int                   recv_pct;
  } step_t;

  typedef struct {
    logic [KBPS_W-1:0] avg;
    logic [KBPS_W-1:0] peak;
  } vote_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  logic                  mode = MODE_REQUEST;
  logic [MBPS_W-1:0]     request_mbps = '0;
  logic [MBPS_W-1:0]     governor_avg_mbps = '0;
  logic                  display_on = 1'b0;
  logic                  suspend_freezing = 1'b0;
  logic [1:0]            outcome = OUTCOME_ACCEPTED;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  vote_valid;
  logic                  vote_stall = 1'b0;
  logic [KBPS_W-1:0]     avg_kbps;
  logic [KBPS_W-1:0]     peak_kbps;

  step_t schedule[$];
  vote_t expected_votes[$];

  int beats_left    = 0;
  int beats_planned = 0;
  int mismatches    = 0;
  int settle_left   = 0;
  int send_pct      = 0;
  int recv_pct      = 0;
  int cycle_count   = 0;
  logic in_fire = 1'b0;

  // Shadow of the last request put on the work list; steers repeats and rises.
  logic [MBPS_W-1:0] shadow_req = '0;
  logic [MBPS_W-1:0] shadow_gav = '0;

  // Predicted block state: register copies plus committed and pending votes.
  logic                  cfg_peak_shared;
  logic                  cfg_split_avg;
  logic [1:0]            cfg_paths;
  logic [PCT_W-1:0]      cfg_upscale;
  logic [PCT_W-1:0]      cfg_boost;
  logic [KBPS_W-1:0]     cfg_min_avg;
  logic [KBPS_W-1:0]     cfg_min_peak;
  logic [MBPS_W-1:0]     committed_peak;
  logic [AVG_MBPS_W-1:0] committed_avg;
  logic [MBPS_W-1:0]     pending_peak;
  logic [AVG_MBPS_W-1:0] pending_avg;
  logic                  pending_live;

  bandwidth_vote_conditioner dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .mode(mode),
    .request_mbps(request_mbps),
    .governor_avg_mbps(governor_avg_mbps),
    .display_on(display_on),
    .suspend_freezing(suspend_freezing),
    .outcome(outcome),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .vote_valid(vote_valid),
    .vote_stall(vote_stall),
    .avg_kbps(avg_kbps),
    .peak_kbps(peak_kbps)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // MB/s to kbps: times 2^20, optional split across paths, over 1000, floor at 1.
  function automatic longint unsigned rate_to_kbps(input logic [AVG_MBPS_W-1:0] rate,
                                                   input logic split);
    longint unsigned v;
    longint unsigned ways;
    v = 64'(rate) * BYTES_PER_MB;
    if (cfg_paths == 2'd0) begin
      ways = 1;
    end else if (cfg_paths > MAX_PATH_COUNT) begin
      ways = MAX_PATH_COUNT;
    end else begin
      ways = 64'(cfg_paths);
    end
    if (split) begin
      v = v / ways;
    end
    v = v / KBPS_DIVISOR;
    if (rate != '0 && v == 0) begin
      v = 1;
    end
    return v;
  endfunction

  // Percentage boost that saturates at the 32-bit vote ceiling.
  function automatic longint unsigned apply_percent(input longint unsigned x,
                                                    input logic [PCT_W-1:0] pct);
    longint unsigned r;
    if (x == 0) begin
      return 0;
    end
    r = (x * 64'(pct)) / PERCENT;
    return (r > KBPS_CEILING) ? KBPS_CEILING : r;
  endfunction

  // Advance the predicted state by one accepted beat; return 1 with the vote
  // when the beat makes the block emit one.
  function automatic bit predict_vote(input logic m, input logic [MBPS_W-1:0] req,
                                      input logic [MBPS_W-1:0] gav, input logic disp,
                                      input logic freeze, input logic [1:0] oc,
                                      output vote_t v);
    logic [AVG_MBPS_W-1:0] avg_rate;
    longint unsigned pk;
    longint unsigned av;
    logic rising;
    v.avg = '0;
    v.peak = '0;
    if (m == MODE_OUTCOME) begin
      // Commit only an accepted pending vote; any other code drops it.
      if (pending_live && oc == OUTCOME_ACCEPTED) begin
        committed_peak = pending_peak;
        committed_avg = pending_avg;
      end
      pending_live = 1'b0;
      return 1'b0;
    end
    rising = req > committed_peak;
    if (gav != '0) begin
      avg_rate = AVG_MBPS_W'(gav);
    end else if (rising) begin
      avg_rate = AVG_MBPS_W'((32'(req) * RISE_NUM) / RISE_DEN);
    end else begin
      avg_rate = AVG_MBPS_W'(req);
    end
    if (req == committed_peak && avg_rate == committed_avg) begin
      return 1'b0;
    end
    if (freeze) begin
      return 1'b0;
    end
    pk = rate_to_kbps(AVG_MBPS_W'(req), cfg_peak_shared);
    av = rate_to_kbps(avg_rate, cfg_split_avg);
    if (disp && rising && cfg_upscale > PCT_UNITY) begin
      av = apply_percent(av, cfg_upscale);
      pk = apply_percent(pk, cfg_upscale);
    end
    if (disp && rising && cfg_boost > PCT_UNITY) begin
      av = apply_percent(av, cfg_boost);
      pk = apply_percent(pk, cfg_boost);
    end
    if (disp && av != 0 && cfg_min_avg != '0 && av < 64'(cfg_min_avg)) begin
      av = 64'(cfg_min_avg);
    end
    if (disp && pk != 0 && cfg_min_peak != '0 && pk < 64'(cfg_min_peak)) begin
      pk = 64'(cfg_min_peak);
    end
    pending_peak = req;
    pending_avg = avg_rate;
    pending_live = 1'b1;
    v.avg = av[KBPS_W-1:0];
    v.peak = pk[KBPS_W-1:0];
    return 1'b1;
  endfunction

  // Register write as the block sees it: mask to width, clamp the percents.
  function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    logic [PCT_W-1:0] pct;
    pct = data[PCT_W-1:0];
    if (pct != '0 && pct < PCT_UNITY) begin
      pct = PCT_UNITY;
    end
    case (idx)
      REG_PEAK_SHARED: cfg_peak_shared = data[0];
      REG_SPLIT_AVG:   cfg_split_avg = data[0];
      REG_PATH_COUNT:  cfg_paths = data[1:0];
      REG_UPSCALE_PCT: cfg_upscale = (pct > UPSCALE_MAX) ? UPSCALE_MAX : pct;
      REG_BOOST_PCT:   cfg_boost = (pct > BOOST_MAX) ? BOOST_MAX : pct;
      REG_MIN_AVG:     cfg_min_avg = data;
      REG_MIN_PEAK:    cfg_min_peak = data;
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Work list construction
  // ---------------------------------------------------------------------------

  task automatic add_beat(input logic m, input logic [MBPS_W-1:0] req,
                          input logic [MBPS_W-1:0] gav, input logic disp,
                          input logic freeze, input logic [1:0] oc);
    step_t s;
    s = '{kind: STEP_BEAT, mode: m, req: req, gav: gav, disp: disp, freeze: freeze,
          oc: oc, reg_idx: '0, reg_data: '0, send_pct: 0, recv_pct: 0};
    schedule.push_back(s);
    beats_left++;
    beats_planned++;
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    step_t s;
    s = '{kind: STEP_REG_WRITE, mode: MODE_REQUEST, req: '0, gav: '0, disp: 1'b0,
          freeze: 1'b0, oc: OUTCOME_ACCEPTED, reg_idx: idx, reg_data: data,
          send_pct: 0, recv_pct: 0};
    schedule.push_back(s);
  endtask

  task automatic add_quiesce();
    step_t s;
    s = '{kind: STEP_QUIESCE, mode: MODE_REQUEST, req: '0, gav: '0, disp: 1'b0,
          freeze: 1'b0, oc: OUTCOME_ACCEPTED, reg_idx: '0, reg_data: '0,
          send_pct: 0, recv_pct: 0};
    schedule.push_back(s);
  endtask

  task automatic add_pace(input int sender, input int receiver);
    step_t s;
    s = '{kind: STEP_PACE, mode: MODE_REQUEST, req: '0, gav: '0, disp: 1'b0,
          freeze: 1'b0, oc: OUTCOME_ACCEPTED, reg_idx: '0, reg_data: '0,
          send_pct: sender, recv_pct: receiver};
    schedule.push_back(s);
  endtask

  // Rate drawn around the previous one: extremes, small, rises, drops, any.
  function automatic logic [MBPS_W-1:0] pick_rate(input logic [MBPS_W-1:0] prev);
    int r;
    case ($urandom_range(0, 7))
      0: r = 0;
      1: r = 16'hFFFF;
      2: r = $urandom_range(0, 15);
      3: begin
        r = int'(prev) + $urandom_range(1, 400);
        if (r > 16'hFFFF) r = 16'hFFFF;
      end
      4: begin
        r = int'(prev) - $urandom_range(1, 400);
        if (r < 0) r = 0;
      end
      default: r = $urandom_range(0, 16'hFFFF);
    endcase
    return MBPS_W'(r);
  endfunction

  function automatic logic [PCT_W-1:0] pick_percent(input int ceiling);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return PCT_W'($urandom_range(1, 99));
      2: return PCT_UNITY;
      3: return PCT_UNITY + 1'b1;
      4: return PCT_W'(ceiling);
      5: return PCT_W'($urandom_range(ceiling + 1, 511));
      default: return PCT_W'($urandom_range(0, 511));
    endcase
  endfunction

  function automatic logic [KBPS_W-1:0] pick_floor();
    case ($urandom_range(0, 6))
      0, 1: return '0;
      2: return 32'd1;
      3: return 32'hFFFF_FFFF;
      4: return $urandom_range(0, 200000);
      5: return $urandom_range(0, 100000000);
      default: return $urandom();
    endcase
  endfunction

  // Drain, then rewrite every register. Upper data bits carry noise on purpose.
  task automatic add_random_settings();
    logic [CFG_DATA_W-1:0] noise;
    add_quiesce();
    add_write(REG_PEAK_SHARED, $urandom());
    add_write(REG_SPLIT_AVG, $urandom());
    add_write(REG_PATH_COUNT, $urandom());
    noise = $urandom();
    add_write(REG_UPSCALE_PCT, {noise[CFG_DATA_W-1:PCT_W], pick_percent(UPSCALE_MAX)});
    noise = $urandom();
    add_write(REG_BOOST_PCT, {noise[CFG_DATA_W-1:PCT_W], pick_percent(BOOST_MAX)});
    add_write(REG_MIN_AVG, pick_floor());
    add_write(REG_MIN_PEAK, pick_floor());
    if ($urandom_range(0, 7) == 0) begin
      add_write(REG_UNUSED, $urandom());
    end
  endtask

  // Mostly request/outcome pairs with random content, some exact repeats to
  // hit the unchanged path, and a share of fully random noise beats.
  task automatic add_random_traffic(input int count);
    int added;
    int pick;
    logic [MBPS_W-1:0] req;
    logic [MBPS_W-1:0] gav;
    logic [1:0] oc;
    added = 0;
    while (added < count) begin
      pick = $urandom_range(0, 99);
      oc = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3)) : OUTCOME_ACCEPTED;
      if (pick < 65) begin
        req = pick_rate(shadow_req);
        gav = ($urandom_range(0, 1) == 0) ? '0 : pick_rate(shadow_gav);
        add_beat(MODE_REQUEST, req, gav, $urandom_range(0, 9) < 7,
                 $urandom_range(0, 9) == 0, 2'($urandom()));
        add_beat(MODE_OUTCOME, MBPS_W'($urandom()), MBPS_W'($urandom()),
                 1'($urandom()), 1'($urandom()), oc);
        shadow_req = req;
        shadow_gav = gav;
        added += 2;
      end else if (pick < 80) begin
        add_beat(MODE_REQUEST, shadow_req, shadow_gav, $urandom_range(0, 9) < 7,
                 1'b0, 2'($urandom()));
        add_beat(MODE_OUTCOME, MBPS_W'($urandom()), MBPS_W'($urandom()),
                 1'($urandom()), 1'($urandom()), oc);
        added += 2;
      end else begin
        add_beat(1'($urandom()), MBPS_W'($urandom()), MBPS_W'($urandom()),
                 1'($urandom()), 1'($urandom()), 2'($urandom()));
        added++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus plan, reset and end of run
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int sender_pace[3];
    int receiver_pace[3];
    sender_pace = '{28, 81, 0};
    receiver_pace = '{81, 28, 0};

    for (int p = 0; p < 3; p++) begin
      add_pace(sender_pace[p], receiver_pace[p]);
      if (p == 0) begin
        // Directed settings: both splits over two paths, top percents, a small
        // average floor and the largest peak floor.
        add_quiesce();
        add_write(REG_PEAK_SHARED, 32'd1);
        add_write(REG_SPLIT_AVG, 32'd1);
        add_write(REG_PATH_COUNT, 32'(PATH_DUAL));
        add_write(REG_UPSCALE_PCT, 32'(UPSCALE_MAX));
        add_write(REG_BOOST_PCT, 32'(BOOST_MAX));
        add_write(REG_MIN_AVG, 32'd5000);
        add_write(REG_MIN_PEAK, 32'hFFFF_FFFF);
        // Outcome with nothing pending: ignored.
        add_beat(MODE_OUTCOME, '0, '0, 1'b1, 1'b0, OUTCOME_ACCEPTED);
        // Zero request equals the reset pair: nothing emitted.
        add_beat(MODE_REQUEST, '0, '0, 1'b1, 1'b0, OUTCOME_ACCEPTED);
        // Largest rising request, no governor average: 9/8 average and both boosts.
        add_beat(MODE_REQUEST, 16'hFFFF, '0, 1'b1, 1'b0, OUTCOME_ACCEPTED);
        add_beat(MODE_OUTCOME, '0, '0, 1'b1, 1'b0, OUTCOME_ACCEPTED);
        // Same peak, average no longer scaled: changed pair, display off.
        add_beat(MODE_REQUEST, 16'hFFFF, '0, 1'b0, 1'b0, OUTCOME_ACCEPTED);
        add_beat(MODE_OUTCOME, '0, '0, 1'b0, 1'b0, OUTCOME_DEFERRED);
        // Deferred leaves the committed pair: the same request votes again.
        add_beat(MODE_REQUEST, 16'hFFFF, '0, 1'b0, 1'b0, OUTCOME_ACCEPTED);
        add_beat(MODE_OUTCOME, '0, '0, 1'b0, 1'b0, OUTCOME_FAILED);
        // Reserved outcome code with nothing pending.
        add_beat(MODE_OUTCOME, '0, '0, 1'b0, 1'b0, OUTCOME_RESERVED);
        // Changed request while suspend is freezing: nothing emitted.
        add_beat(MODE_REQUEST, 16'd1, '0, 1'b1, 1'b1, OUTCOME_ACCEPTED);
        // Falling request with display on: floors, no boosts.
        add_beat(MODE_REQUEST, 16'd1, '0, 1'b1, 1'b0, OUTCOME_ACCEPTED);
        add_beat(MODE_OUTCOME, '0, '0, 1'b1, 1'b0, OUTCOME_ACCEPTED);
        // Governor average equal to the committed one: unchanged.
        add_beat(MODE_REQUEST, 16'd1, 16'd1, 1'b1, 1'b0, OUTCOME_ACCEPTED);
        // Rising with the largest governor average.
        add_beat(MODE_REQUEST, 16'd2, 16'hFFFF, 1'b1, 1'b0, OUTCOME_ACCEPTED);
        add_beat(MODE_OUTCOME, '0, '0, 1'b1, 1'b0, OUTCOME_RESERVED);
        // Zero request against a nonzero committed pair: zero votes, no floors.
        add_beat(MODE_REQUEST, '0, '0, 1'b1, 1'b0, OUTCOME_ACCEPTED);
        add_beat(MODE_OUTCOME, '0, '0, 1'b1, 1'b0, OUTCOME_ACCEPTED);
        // Two requests in a row: the second overwrites the pending vote.
        add_beat(MODE_REQUEST, 16'd7, '0, 1'b1, 1'b0, OUTCOME_ACCEPTED);
        add_beat(MODE_REQUEST, 16'd3, 16'd9, 1'b1, 1'b0, OUTCOME_ACCEPTED);
        add_beat(MODE_OUTCOME, '0, '0, 1'b1, 1'b0, OUTCOME_ACCEPTED);
        shadow_req = 16'd3;
        shadow_gav = 16'd9;
      end
      while (beats_planned < (TARGET_BEATS * (p + 1)) / 3) begin
        add_random_settings();
        add_random_traffic($urandom_range(30, 90));
      end
    end

    // Hold reset, then release it on a falling edge.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait until every beat is taken and every vote has come, then let the
    // block settle so a stray vote still shows up.
    do begin
      @(negedge clk);
    end while (beats_left != 0 || expected_votes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: walk the work list on falling edges
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin : drive_items
    logic next_valid;
    logic next_write;
    next_valid = item_valid;
    next_write = 1'b0;
    if (!rst) begin
      // Drop valid once the last rising edge took the beat.
      if (item_valid && in_fire) begin
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (settle_left > 0) begin
          settle_left--;
        end else if (schedule.size() > 0) begin
          case (schedule[0].kind)
            STEP_BEAT: begin
              // Idle the sender at random; otherwise present the next beat.
              if ($urandom_range(0, 99) >= send_pct) begin
                next_valid = 1'b1;
                mode <= schedule[0].mode;
                request_mbps <= schedule[0].req;
                governor_avg_mbps <= schedule[0].gav;
                display_on <= schedule[0].disp;
                suspend_freezing <= schedule[0].freeze;
                outcome <= schedule[0].oc;
                void'(schedule.pop_front());
              end
            end
            STEP_REG_WRITE: begin
              next_write = 1'b1;
              cfg_index <= schedule[0].reg_idx;
              cfg_data <= schedule[0].reg_data;
              void'(schedule.pop_front());
            end
            STEP_QUIESCE: begin
              // Hold off until every vote is back, then wait out any silent beat.
              if (expected_votes.size() == 0) begin
                settle_left = SETTLE_CYCLES;
                void'(schedule.pop_front());
              end
            end
            default: begin
              send_pct = schedule[0].send_pct;
              recv_pct = schedule[0].recv_pct;
              void'(schedule.pop_front());
            end
          endcase
        end
      end
    end
    item_valid <= next_valid;
    cfg_write <= next_write;
  end

  // Receiver: stall the vote channel at random.
  always @(negedge clk) begin
    vote_stall <= !rst && ($urandom_range(0, 99) < recv_pct);
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels and the write port on rising edges
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : watch_ports
    vote_t want;
    vote_t fresh;
    if (rst) begin
      in_fire <= 1'b0;
      cfg_peak_shared = 1'b0;
      cfg_split_avg = 1'b1;
      cfg_paths = PATH_ONE;
      cfg_upscale = '0;
      cfg_boost = '0;
      cfg_min_avg = '0;
      cfg_min_peak = '0;
      committed_peak = '0;
      committed_avg = '0;
      pending_peak = '0;
      pending_avg = '0;
      pending_live = 1'b0;
    end else begin
      in_fire <= item_valid && !item_stall;
      // Check the vote beat first: a beat taken on this edge cannot be its source.
      if (vote_valid && !vote_stall) begin
        if (expected_votes.size() == 0) begin
          report_mismatch($sformatf("vote with none expected: avg_kbps %0d peak_kbps %0d",
                                    avg_kbps, peak_kbps));
        end else begin
          want = expected_votes.pop_front();
          if (avg_kbps !== want.avg) begin
            report_mismatch($sformatf("avg_kbps %0d, expected %0d", avg_kbps, want.avg));
          end
          if (peak_kbps !== want.peak) begin
            report_mismatch($sformatf("peak_kbps %0d, expected %0d", peak_kbps, want.peak));
          end
        end
      end
      if (cfg_write) begin
        apply_setting(cfg_index, cfg_data);
      end
      if (item_valid && !item_stall) begin
        beats_left--;
        if (predict_vote(mode, request_mbps, governor_avg_mbps, display_on,
                         suspend_freezing, outcome, fresh)) begin
          expected_votes.push_back(fresh);
        end
      end
    end
  end

endmodule
